// File: design/fixed_site_likelihood_caller_assert.svh
// Assertion macros for the checker file of this block.
`ifndef FIXED_SITE_LIKELIHOOD_CALLER_ASSERT_SVH
`define FIXED_SITE_LIKELIHOOD_CALLER_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define FSLC_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fslc check failed");

// Next-cycle implication that also holds across reset.
`define FSLC_ASSERT_NEXT(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("fslc check failed");

`endif

// File: design/fslc_pkg.sv
package fslc_pkg;

  localparam int LOGQ    = 28;
  localparam int LOG_W   = 34;
  localparam int LOG_LAT = 30;
  localparam int LATENCY = 41;

  localparam logic [27:0] LN2_Q28    = 28'd186065280;
  localparam logic [61:0] TERM_LIMIT = 62'(1) << 61;
  localparam logic [39:0] OUT_MAX    = 40'h7F_FFFF_FFFF;
  localparam logic [39:0] OUT_MIN    = 40'h80_0000_0000;

  localparam logic [2:0] BASE_N    = 3'd4;
  localparam logic [2:0] BASE_NONE = 3'd5;

  typedef enum logic [1:0] {
    CFG_EPSILON     = 2'd0,
    CFG_MAJOR_FREQ  = 2'd1,
    CFG_FIXED_LIMIT = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [15:0] count_a;
    logic [15:0] count_c;
    logic [15:0] count_g;
    logic [15:0] count_t;
    logic [11:0] column;
  } item_t;

  typedef struct packed {
    logic        call_type;
    logic [2:0]  first_base;
    logic [2:0]  second_base;
    logic [39:0] ratio_value;
    logic [11:0] column_out;
  } result_t;

endpackage

// File: design/fslc_log2.sv
module fslc_log2 #(
  parameter int IN_W = 36
) (
  input  logic                          clk,
  input  logic [IN_W-1:0]               x,
  output logic [fslc_pkg::LOG_W-1:0]    y
);

  localparam int NW = (IN_W > 32) ? IN_W : 32;
  localparam int KW = $clog2(NW);
  localparam int NS = fslc_pkg::LOGQ;

  logic [NW-1:0] xr;
  logic [KW-1:0] kr;
  logic [KW-1:0] k_find;
  logic [KW-1:0] sh;
  logic [NW-1:0] xs;

  logic [31:0]   m_st [0:NS];
  logic [KW-1:0] k_st [0:NS];
  logic [NS-1:0] f_st [0:NS];

  // Position of the top set bit; zero input gives zero, which yields log 0.
  always_comb begin
    k_find = '0;
    for (int i = 0; i < NW; i++) begin
      if (xr[i]) begin
        k_find = KW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    xr <= NW'(x);
  end

  always_comb begin
    sh = KW'(NW - 1) - k_find;
    xs = xr << sh;
  end

  always_ff @(posedge clk) begin
    m_st[0] <= xs[NW-1 -: 32];
    k_st[0] <= k_find;
    f_st[0] <= '0;
  end

  // One fraction bit per stage by squaring the mantissa.
  for (genvar j = 1; j <= NS; j++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] t;
    assign sq = {32'b0, m_st[j-1]} * {32'b0, m_st[j-1]};
    assign t  = sq[63:31];
    always_ff @(posedge clk) begin
      m_st[j] <= t[32] ? t[32:1] : t[31:0];
      f_st[j] <= {f_st[j-1][NS-2:0], t[32]};
      k_st[j] <= k_st[j-1];
    end
  end

  assign y = {(fslc_pkg::LOG_W - NS)'(k_st[NS]), f_st[NS]};

endmodule

// File: design/fixed_site_likelihood_caller.sv
// A column accepted with start has its result on the ports with done high; one column
// enters in every cycle and busy stays low. The log2 units hold two normalize stages and
// 28 squaring stages, each one 32x32 multiply; eleven more stages do ranking, products,
// scaling and output.
// Reset clears the pipeline valid bits and loads the configuration reset values.
// Results are not held: the receiver takes each one in the cycle it is shown.
module fixed_site_likelihood_caller #(
  parameter int COUNT_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  fslc_pkg::item_t    item,
  output logic               done,
  output fslc_pkg::result_t  result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int CB    = COUNT_BITS;
  localparam int SW    = CB + 1;
  localparam int AW    = CB + 17;
  localparam int NUMW  = CB + 20;
  localparam int DENW  = 36;
  localparam int DW    = 37;
  localparam int LOWW  = 19;
  localparam int HIW   = DW - LOWW;
  localparam int PW    = DW + CB;
  localparam int PXW   = (PW > 63) ? PW : 63;
  localparam int LGW   = fslc_pkg::LOG_W;
  localparam int LAT   = fslc_pkg::LATENCY;
  localparam int LLAT  = fslc_pkg::LOG_LAT;
  localparam logic [DW-1:0] LOG_OFFSET = DW'(16) << fslc_pkg::LOGQ;

  // Side data that rides alongside the log2 units and the scaling stages.
  typedef struct packed {
    logic [CB-1:0] n1;
    logic [CB-1:0] n2;
    logic [2:0]    b1;
    logic [2:0]    b2;
    logic [11:0]   col;
    logic          freq_low;
    logic          zero;
    logic          d1zero;
  } side_t;

  // The pipeline never stalls, so a new column is always welcome.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  logic accept;
  assign accept = start && !busy;

  // Configuration registers. They are to be written only while the pipe is empty; the block does not enforce it.
  logic [15:0] error_epsilon;
  logic [15:0] major_freq;
  logic [31:0] fixed_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      error_epsilon <= 16'd0;
      major_freq    <= 16'd32768;
      fixed_limit   <= 32'd125829;
    end else if (cfg_valid && cfg_ready) begin
      case (fslc_pkg::cfg_index_t'(cfg_index))
        fslc_pkg::CFG_EPSILON:     error_epsilon <= cfg_data[15:0];
        fslc_pkg::CFG_MAJOR_FREQ:  major_freq    <= cfg_data[15:0];
        fslc_pkg::CFG_FIXED_LIMIT: fixed_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [16:0] w;
  logic [16:0] pc;
  assign w  = 17'h10000 - 17'(error_epsilon);
  assign pc = 17'h10000 - 17'(major_freq);

  // One valid bit per stage; done is the last one.
  logic [LAT-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], accept};
    end
  end
  assign done = vld[LAT-1];

  // Stage 1: rank the four bases. A base's rank counts the bases that beat it,
  // where an equal count earlier in A, C, G, T order also beats it.
  logic [CB-1:0] cnt [4];
  logic [1:0]    rank [4];
  logic [2:0]    sel1, sel2;

  always_comb begin
    cnt[0] = CB'(item.count_a);
    cnt[1] = CB'(item.count_c);
    cnt[2] = CB'(item.count_g);
    cnt[3] = CB'(item.count_t);
    for (int i = 0; i < 4; i++) begin
      rank[i] = 2'd0;
      for (int j = 0; j < 4; j++) begin
        if (j != i && (cnt[j] > cnt[i] || (cnt[j] == cnt[i] && j < i))) begin
          rank[i] = rank[i] + 2'd1;
        end
      end
    end
    sel1 = 3'd0;
    sel2 = 3'd0;
    for (int i = 0; i < 4; i++) begin
      if (rank[i] == 2'd0) begin
        sel1 = 3'(i);
      end
      if (rank[i] == 2'd1) begin
        sel2 = 3'(i);
      end
    end
  end

  logic [CB-1:0] p1_n1, p1_n2;
  logic [2:0]    p1_b1, p1_b2;
  logic [11:0]   p1_col;

  always_ff @(posedge clk) begin
    p1_n1  <= cnt[sel1[1:0]];
    p1_n2  <= cnt[sel2[1:0]];
    p1_b1  <= sel1;
    p1_b2  <= sel2;
    p1_col <= item.column;
  end

  // Stage 2: pair sum and the count-times-weight products.
  logic [SW-1:0] p2_s;
  logic [AW-1:0] p2_a1, p2_a2;
  logic [CB-1:0] p2_n1, p2_n2;
  logic [2:0]    p2_b1, p2_b2;
  logic [11:0]   p2_col;

  always_ff @(posedge clk) begin
    p2_s   <= SW'(p1_n1) + SW'(p1_n2);
    p2_a1  <= AW'(p1_n1) * AW'(w);
    p2_a2  <= AW'(p1_n2) * AW'(w);
    p2_n1  <= p1_n1;
    p2_n2  <= p1_n2;
    p2_b1  <= p1_b1;
    p2_b2  <= p1_b2;
    p2_col <= p1_col;
  end

  // Stage 3: error share of the sum, frequency product, denominator products.
  logic [AW-1:0] p3_se, p3_ps, p3_a1, p3_a2;
  logic [32:0]   p3_pw, p3_qw;
  logic [SW-1:0] p3_s;
  logic [CB-1:0] p3_n1, p3_n2;
  logic [2:0]    p3_b1, p3_b2;
  logic [11:0]   p3_col;

  always_ff @(posedge clk) begin
    p3_se  <= AW'(p2_s) * AW'(error_epsilon);
    p3_ps  <= AW'(p2_s) * AW'(major_freq);
    p3_pw  <= 33'(major_freq) * 33'(w);
    p3_qw  <= 33'(pc) * 33'(w);
    p3_a1  <= p2_a1;
    p3_a2  <= p2_a2;
    p3_s   <= p2_s;
    p3_n1  <= p2_n1;
    p3_n2  <= p2_n2;
    p3_b1  <= p2_b1;
    p3_b2  <= p2_b2;
    p3_col <= p2_col;
  end

  // Stage 4: numerators and denominators that feed the log2 units.
  logic [NUMW-1:0] p4_num1, p4_num2;
  logic [DENW-1:0] p4_d1, p4_d2, d1_next;
  logic [SW-1:0]   p4_s;
  side_t           p4_side;

  assign d1_next = (DENW'(p3_pw) << 2) + (DENW'(error_epsilon) << 16);

  always_ff @(posedge clk) begin
    p4_num1          <= (NUMW'(p3_a1) << 2) + NUMW'(p3_se);
    p4_num2          <= (NUMW'(p3_a2) << 2) + NUMW'(p3_se);
    p4_d1            <= d1_next;
    p4_d2            <= (DENW'(p3_qw) << 2) + (DENW'(error_epsilon) << 16);
    p4_s             <= p3_s;
    p4_side.n1       <= p3_n1;
    p4_side.n2       <= p3_n2;
    p4_side.b1       <= p3_b1;
    p4_side.b2       <= p3_b2;
    p4_side.col      <= p3_col;
    // Exact form of n1/s < p.
    p4_side.freq_low <= (AW'(p3_n1) << 16) < p3_ps;
    p4_side.zero     <= (p3_n1 == '0);
    p4_side.d1zero   <= (d1_next == '0);
  end

  // Five log2 pipelines run in lockstep.
  logic [LGW-1:0] lg_num1, lg_num2, lg_s, lg_d1, lg_d2;

  fslc_log2 #(.IN_W(NUMW)) u_lg_num1 (.clk(clk), .x(p4_num1), .y(lg_num1));
  fslc_log2 #(.IN_W(NUMW)) u_lg_num2 (.clk(clk), .x(p4_num2), .y(lg_num2));
  fslc_log2 #(.IN_W(SW))   u_lg_s    (.clk(clk), .x(p4_s),    .y(lg_s));
  fslc_log2 #(.IN_W(DENW)) u_lg_d1   (.clk(clk), .x(p4_d1),   .y(lg_d1));
  fslc_log2 #(.IN_W(DENW)) u_lg_d2   (.clk(clk), .x(p4_d2),   .y(lg_d2));

  side_t side_dly [0:LLAT-1];
  always_ff @(posedge clk) begin
    side_dly[0] <= p4_side;
    for (int i = 1; i < LLAT; i++) begin
      side_dly[i] <= side_dly[i-1];
    end
  end

  // Stage A: log differences in Q28, held in two's complement.
  logic [DW-1:0] a_d1, a_d2;
  side_t         a_side;

  always_ff @(posedge clk) begin
    a_d1   <= DW'(lg_num1) + LOG_OFFSET - DW'(lg_s) - DW'(lg_d1);
    a_d2   <= DW'(lg_num2) + LOG_OFFSET - DW'(lg_s) - DW'(lg_d2);
    a_side <= side_dly[LLAT-1];
  end

  // Stage B: magnitude times count, split into two partial products.
  logic [DW-1:0] mag1, mag2;
  assign mag1 = a_d1[DW-1] ? (DW'(0) - a_d1) : a_d1;
  assign mag2 = a_d2[DW-1] ? (DW'(0) - a_d2) : a_d2;

  logic [LOWW+CB-1:0] b_plo1, b_plo2;
  logic [HIW+CB-1:0]  b_phi1, b_phi2;
  logic               b_neg1, b_neg2, b_dz1, b_dz2;
  side_t              b_side;

  always_ff @(posedge clk) begin
    b_plo1 <= (LOWW+CB)'(mag1[LOWW-1:0]) * (LOWW+CB)'(a_side.n1);
    b_phi1 <= (HIW+CB)'(mag1[DW-1:LOWW]) * (HIW+CB)'(a_side.n1);
    b_plo2 <= (LOWW+CB)'(mag2[LOWW-1:0]) * (LOWW+CB)'(a_side.n2);
    b_phi2 <= (HIW+CB)'(mag2[DW-1:LOWW]) * (HIW+CB)'(a_side.n2);
    b_neg1 <= a_d1[DW-1];
    b_neg2 <= a_d2[DW-1];
    b_dz1  <= (a_d1 == '0);
    b_dz2  <= (a_d2 == '0);
    b_side <= a_side;
  end

  // Stage C: combine partial products and saturate each term at 2^61.
  logic [PXW-1:0] prod1, prod2;
  logic [61:0]    tm1, tm2;
  logic           tn1, tn2;

  assign prod1 = (PXW'(b_phi1) << LOWW) + PXW'(b_plo1);
  assign prod2 = (PXW'(b_phi2) << LOWW) + PXW'(b_plo2);

  always_comb begin
    if (b_side.d1zero) begin
      tm1 = fslc_pkg::TERM_LIMIT;
      tn1 = 1'b0;
    end else if (b_side.n1 == '0 || b_dz1) begin
      tm1 = '0;
      tn1 = 1'b0;
    end else begin
      tm1 = (prod1 > PXW'(fslc_pkg::TERM_LIMIT)) ? fslc_pkg::TERM_LIMIT : prod1[61:0];
      tn1 = b_neg1;
    end
    // A missing second base contributes nothing.
    if (b_side.n2 == '0 || b_dz2) begin
      tm2 = '0;
      tn2 = 1'b0;
    end else begin
      tm2 = (prod2 > PXW'(fslc_pkg::TERM_LIMIT)) ? fslc_pkg::TERM_LIMIT : prod2[61:0];
      tn2 = b_neg2;
    end
  end

  logic [61:0] c_tm1, c_tm2;
  logic        c_tn1, c_tn2;
  side_t       c_side;

  always_ff @(posedge clk) begin
    c_tm1  <= tm1;
    c_tm2  <= tm2;
    c_tn1  <= tn1;
    c_tn2  <= tn2;
    c_side <= b_side;
  end

  // Stage D: signed sum, clamped to plus or minus 2^61.
  logic signed [63:0] ts1, ts2, tsum;
  logic               sum_neg;
  logic [63:0]        sum_abs;

  assign ts1     = c_tn1 ? -$signed(64'(c_tm1)) : $signed(64'(c_tm1));
  assign ts2     = c_tn2 ? -$signed(64'(c_tm2)) : $signed(64'(c_tm2));
  assign tsum    = ts1 + ts2;
  assign sum_neg = tsum[63];
  assign sum_abs = sum_neg ? (64'(0) - 64'(tsum)) : 64'(tsum);

  logic        d_neg;
  logic [61:0] d_mag;
  side_t       d_side;

  always_ff @(posedge clk) begin
    d_neg  <= sum_neg;
    d_mag  <= (sum_abs > 64'(fslc_pkg::TERM_LIMIT)) ? fslc_pkg::TERM_LIMIT : sum_abs[61:0];
    d_side <= c_side;
  end

  // Stage E: convert to natural log, integer and fraction parts separately.
  logic [61:0] e_pa;
  logic [55:0] e_pb;
  logic        e_neg;
  side_t       e_side;

  always_ff @(posedge clk) begin
    e_pa   <= 62'(d_mag[61:28]) * 62'(fslc_pkg::LN2_Q28);
    e_pb   <= 56'(d_mag[27:0]) * 56'(fslc_pkg::LN2_Q28);
    e_neg  <= d_neg;
    e_side <= d_side;
  end

  // Stage F: drop to the output fraction width and saturate to 40 bits.
  logic [62:0] q, qs;
  logic [39:0] ratio_next;

  assign q  = 63'(e_pa) + 63'(e_pb[55:28]);
  assign qs = q >> (fslc_pkg::LOGQ - FRAC_BITS);

  always_comb begin
    if (!e_neg) begin
      ratio_next = (qs > 63'(fslc_pkg::OUT_MAX)) ? fslc_pkg::OUT_MAX : qs[39:0];
    end else if (qs > 63'(fslc_pkg::OUT_MAX)) begin
      ratio_next = fslc_pkg::OUT_MIN;
    end else begin
      ratio_next = 40'(0) - qs[39:0];
    end
  end

  logic [39:0] f_ratio;
  side_t       f_side;

  always_ff @(posedge clk) begin
    f_ratio <= ratio_next;
    f_side  <= e_side;
  end

  // Stage G: threshold test at a common scale and the call itself.
  logic signed [57:0] cmp_l, cmp_r;
  logic               unk;

  assign cmp_l = {{2{f_ratio[39]}}, f_ratio, 16'b0};
  assign cmp_r = 58'(fixed_limit) << FRAC_BITS;
  assign unk   = f_side.freq_low || (cmp_l < cmp_r);

  always_ff @(posedge clk) begin
    result.column_out <= f_side.col;
    if (f_side.zero) begin
      result.call_type   <= 1'b1;
      result.first_base  <= fslc_pkg::BASE_N;
      result.second_base <= fslc_pkg::BASE_NONE;
      result.ratio_value <= '0;
    end else begin
      result.call_type   <= unk;
      result.first_base  <= f_side.b1;
      result.second_base <= (unk && f_side.n2 != '0) ? f_side.b2 : fslc_pkg::BASE_NONE;
      result.ratio_value <= f_ratio;
    end
  end

endmodule

// File: design/fslc_checker.sv
`include "fixed_site_likelihood_caller_assert.svh"

module fslc_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input fslc_pkg::result_t  result
);

  // Every accepted column comes out a fixed number of cycles later.
  `FSLC_ASSERT_IMP(a_latency, clk, rst, start && !busy, ##(fslc_pkg::LATENCY) done)

  // A column with no reads gives the dummy result.
  `FSLC_ASSERT_IMP(a_dummy, clk, rst, done && result.first_base == fslc_pkg::BASE_N, result.call_type && result.second_base == fslc_pkg::BASE_NONE && result.ratio_value == '0)

  // A fixed call never names a second base.
  `FSLC_ASSERT_IMP(a_fixed, clk, rst, done && !result.call_type, result.second_base == fslc_pkg::BASE_NONE)

  // Reset empties the pipeline.
  `FSLC_ASSERT_NEXT(a_reset, clk, rst, !done)

endmodule

bind fixed_site_likelihood_caller fslc_checker u_fslc_checker (.*);

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  typedef longint unsigned u64_t;

  // Register index that the block does not decode; a write to it must change nothing.
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  // Stop the run if it goes far beyond the slowest correct schedule.
  localparam int CYCLE_LIMIT = 200000;

  // The scoreboard keeps its own copy of the three registers and predicts the
  // call for each accepted column. Expected calls wait in order of acceptance,
  // since the pipeline has a fixed latency and never reorders.
  class call_scoreboard;
    logic [15:0]       epsilon = 16'd0;
    logic [15:0]       freq    = 16'd32768;
    logic [31:0]       limit   = 32'd125829;
    fslc_pkg::result_t calls_due[$];
    int                errors  = 0;

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    function void queue_call(fslc_pkg::result_t r);
      calls_due = {calls_due, r};
    endfunction

    function void write_register(logic [1:0] index, logic [31:0] data);
      case (index)
        fslc_pkg::CFG_EPSILON:     epsilon = data[15:0];
        fslc_pkg::CFG_MAJOR_FREQ:  freq    = data[15:0];
        fslc_pkg::CFG_FIXED_LIMIT: limit   = data;
        default: ;
      endcase
    endfunction

    // Base-2 log in Q28: integer part from the top set bit, fraction by squaring.
    function u64_t log2_q28(u64_t x);
      int k;
      u64_t m;
      u64_t f;
      f = 0;
      if (x == 0) return 0;
      k = 63;
      while (x[k] == 1'b0) k--;
      m = (k >= 31) ? (x >> (k - 31)) : (x << (31 - k));
      for (int i = 0; i < 28; i++) begin
        m = (m * m) >> 31;
        f = f << 1;
        if (m >= 64'h1_0000_0000) begin
          m = m >> 1;
          f = f | 64'd1;
        end
      end
      return (u64_t'(k) << 28) | f;
    endfunction

    function longint log_ratio(u64_t num, u64_t s, u64_t den);
      longint v;
      v = longint'(log2_q28(num)) + (longint'(16) << 28);
      v = v - longint'(log2_q28(s));
      v = v - longint'(log2_q28(den));
      return v;
    endfunction

    // Weight a log term by its count; the magnitude saturates at the term limit.
    function longint weigh(u64_t n, longint d);
      u64_t mag;
      u64_t cap;
      bit neg;
      if (n == 0 || d == 0) return 0;
      cap = u64_t'(fslc_pkg::TERM_LIMIT);
      neg = d < 0;
      mag = neg ? u64_t'(-d) : u64_t'(d);
      if (mag > cap / n) mag = cap;
      else mag = mag * n;
      return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function void note_column(fslc_pkg::item_t it);
      u64_t cnt[4];
      int order[4];
      int v, j;
      u64_t n1, n2, s, e, p, w, num1, num2, d1, d2, mag, a, b, q;
      u64_t out_max, lim_cap;
      longint t1, t2, total, ratio;
      bit neg, unk;
      fslc_pkg::result_t r;
      cnt[0] = it.count_a;
      cnt[1] = it.count_c;
      cnt[2] = it.count_g;
      cnt[3] = it.count_t;
      for (int i = 0; i < 4; i++) order[i] = i;
      // Stable insertion sort: equal counts keep A, C, G, T order.
      for (int i = 1; i < 4; i++) begin
        v = order[i];
        j = i;
        while (j > 0 && cnt[v] > cnt[order[j - 1]]) begin
          order[j] = order[j - 1];
          j--;
        end
        order[j] = v;
      end
      r.column_out = it.column;
      n1 = cnt[order[0]];
      n2 = cnt[order[1]];
      if (n1 == 0) begin
        r.call_type   = 1'b1;
        r.first_base  = fslc_pkg::BASE_N;
        r.second_base = fslc_pkg::BASE_NONE;
        r.ratio_value = '0;
        queue_call(r);
        return;
      end
      s = n1 + n2;
      e = epsilon;
      p = freq;
      w = 65536 - e;
      num1 = 4 * n1 * w + s * e;
      d1 = 4 * p * w + 65536 * e;
      // With no error and a zero frequency the first denominator vanishes.
      if (d1 == 0) t1 = longint'(fslc_pkg::TERM_LIMIT);
      else t1 = weigh(n1, log_ratio(num1, s, d1));
      if (n2 == 0) begin
        t2 = 0;
      end else begin
        num2 = 4 * n2 * w + s * e;
        d2 = 4 * (65536 - p) * w + 65536 * e;
        t2 = weigh(n2, log_ratio(num2, s, d2));
      end
      total = t1 + t2;
      if (total > longint'(fslc_pkg::TERM_LIMIT)) total = longint'(fslc_pkg::TERM_LIMIT);
      if (total < -longint'(fslc_pkg::TERM_LIMIT)) total = -longint'(fslc_pkg::TERM_LIMIT);
      // Convert to natural log, then drop to the output fraction width.
      neg = total < 0;
      mag = neg ? u64_t'(-total) : u64_t'(total);
      a = mag >> 28;
      b = mag & 64'hFFF_FFFF;
      q = a * u64_t'(fslc_pkg::LN2_Q28) + ((b * u64_t'(fslc_pkg::LN2_Q28)) >> 28);
      q = q >> 12;
      out_max = u64_t'(fslc_pkg::OUT_MAX);
      if (!neg && q > out_max) ratio = longint'(out_max);
      else if (neg && q >= out_max + 1) ratio = -longint'(out_max) - 1;
      else if (neg) ratio = -longint'(q);
      else ratio = longint'(q);
      lim_cap = u64_t'(limit) << 16;
      unk = (n1 * 65536 < p * s) || (ratio * 65536 < longint'(lim_cap));
      r.call_type   = unk;
      r.first_base  = 3'(order[0]);
      r.second_base = (unk && n2 > 0) ? 3'(order[1]) : fslc_pkg::BASE_NONE;
      r.ratio_value = ratio[39:0];
      queue_call(r);
    endfunction

    task check_call(fslc_pkg::result_t got);
      fslc_pkg::result_t want;
      if (calls_due.size() == 0) begin
        report($sformatf("call for column %0d with none expected", got.column_out));
        return;
      end
      want = calls_due.pop_front();
      if (got.call_type !== want.call_type)
        report($sformatf("col %0d call_type %0d want %0d",
                         want.column_out, got.call_type, want.call_type));
      if (got.first_base !== want.first_base)
        report($sformatf("col %0d first_base %0d want %0d",
                         want.column_out, got.first_base, want.first_base));
      if (got.second_base !== want.second_base)
        report($sformatf("col %0d second_base %0d want %0d",
                         want.column_out, got.second_base, want.second_base));
      if (got.ratio_value !== want.ratio_value)
        report($sformatf("col %0d ratio_value %h want %h",
                         want.column_out, got.ratio_value, want.ratio_value));
      if (got.column_out !== want.column_out)
        report($sformatf("column_out %0d want %0d", got.column_out, want.column_out));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  fslc_pkg::item_t   item = '0;
  logic              done;
  fslc_pkg::result_t result;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = '0;
  logic [31:0]       cfg_data = '0;

  call_scoreboard calls = new();
  int cycles = 0;
  // Share of cycles, in a hundred, in which the sender idles.
  int gap_percent = 0;

  fixed_site_likelihood_caller i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item), .done(done),
    .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Inputs change only on nonblocking assignments at the edge, so values read
  // here are the ones the block saw at this edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) calls.note_column(item);
      if (done) calls.check_call(result);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench: done, errors");
      $finish;
    end
  end

  // One column transfer; each cycle before it the sender may idle, and start
  // stays high until busy is seen low at an edge.
  task send_column(fslc_pkg::item_t it);
    while ($urandom_range(99) < gap_percent) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
  endtask

  // Let the pipeline drain completely so that a register can change safely.
  task drain;
    start <= 1'b0;
    @(posedge clk);
    while (calls.calls_due.size() != 0) @(posedge clk);
    repeat (fslc_pkg::LATENCY + 4) @(posedge clk);
  endtask

  task write_config(logic [1:0] index, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    calls.write_register(index, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function fslc_pkg::item_t make_column(int c_a, int c_c, int c_g, int c_t, int col);
    fslc_pkg::item_t it;
    it.count_a = 16'(c_a);
    it.count_c = 16'(c_c);
    it.count_g = 16'(c_g);
    it.count_t = 16'(c_t);
    it.column  = 12'(col);
    return it;
  endfunction

  // Four in ten are columns dominated by one base, which is what reaches the fixed call;
  // the rest spread over full-range, tiny, tied, empty and single-base columns.
  function fslc_pkg::item_t random_column();
    fslc_pkg::item_t it;
    int top;
    int mode;
    it = make_column($urandom, $urandom, $urandom, $urandom, $urandom);
    mode = $urandom_range(9);
    case (mode)
      0, 1, 2, 3: begin
        top = $urandom_range(1, 65535);
        it = make_column($urandom_range(top / 8), $urandom_range(top / 8),
                         $urandom_range(top / 8), $urandom_range(top / 8), $urandom);
        case ($urandom_range(3))
          0: it.count_a = 16'(top);
          1: it.count_c = 16'(top);
          2: it.count_g = 16'(top);
          default: it.count_t = 16'(top);
        endcase
      end
      4, 5: ;
      6: it = make_column($urandom_range(20), $urandom_range(20), $urandom_range(20),
                          $urandom_range(20), $urandom);
      7: begin
        top = $urandom_range(65535);
        it = make_column(top, top, $urandom_range(top), top, $urandom);
      end
      8: it = make_column(0, 0, 0, 0, $urandom);
      default: begin
        top = $urandom_range(1, 65535);
        it = make_column(0, 0, 0, 0, $urandom);
        if ($urandom_range(1)) it.count_g = 16'(top);
        else it.count_c = 16'(top);
      end
    endcase
    return it;
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed columns under the reset register values.
    gap_percent = 10;
    send_column(make_column(0, 0, 0, 0, 0));
    send_column(make_column(0, 0, 0, 0, 4095));
    send_column(make_column(65535, 65535, 65535, 65535, 1));
    send_column(make_column(65535, 0, 0, 0, 2));
    send_column(make_column(0, 0, 0, 65535, 3));
    send_column(make_column(0, 1, 0, 0, 4));
    send_column(make_column(5, 5, 0, 0, 5));
    send_column(make_column(0, 0, 7, 7, 6));
    send_column(make_column(100, 1, 0, 0, 7));
    send_column(make_column(1, 100, 3, 2, 8));
    send_column(make_column(65535, 65534, 0, 0, 9));
    send_column(make_column(3, 2, 2, 1, 10));
    send_column(make_column(0, 40000, 1, 0, 11));
    send_column(make_column(1, 1, 1, 1, 2730));
    send_column(make_column(12, 0, 0, 900, 1365));

    // Each phase but the first loads a new register setting, extremes included; every
    // phase streams random columns, and the drain before each write is the full pause.
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0: ;
        1: begin
          write_config(fslc_pkg::CFG_EPSILON, 32'd655);
          write_config(fslc_pkg::CFG_MAJOR_FREQ, 32'd52429);
          write_config(fslc_pkg::CFG_FIXED_LIMIT, 32'd125829);
        end
        2: begin
          write_config(fslc_pkg::CFG_EPSILON, 32'd65535);
          write_config(fslc_pkg::CFG_MAJOR_FREQ, 32'd1);
          write_config(fslc_pkg::CFG_FIXED_LIMIT, 32'd0);
        end
        3: begin
          write_config(fslc_pkg::CFG_EPSILON, 32'd0);
          write_config(fslc_pkg::CFG_MAJOR_FREQ, 32'd65535);
          write_config(fslc_pkg::CFG_FIXED_LIMIT, 32'hFFFF_FFFF);
        end
        4: begin
          // Zero frequency with zero error makes the first denominator vanish.
          write_config(fslc_pkg::CFG_MAJOR_FREQ, 32'hFFFF_0000);
          write_config(fslc_pkg::CFG_FIXED_LIMIT, 32'd0);
          write_config(CFG_UNUSED, $urandom);
        end
        default: begin
          write_config(fslc_pkg::CFG_EPSILON, $urandom);
          write_config(fslc_pkg::CFG_MAJOR_FREQ, $urandom_range(1, 65535));
          write_config(fslc_pkg::CFG_FIXED_LIMIT, $urandom_range(0, 32'h0010_0000));
        end
      endcase
      if (phase < 2) gap_percent = 10;
      else if (phase < 4) gap_percent = 52;
      else gap_percent = 0;
      if (phase == 4) send_column(make_column(9, 3, 0, 0, 77));
      for (int n = 0; n < 225; n++) send_column(random_column());
    end

    start <= 1'b0;
    @(posedge clk);
    while (calls.calls_due.size() != 0) @(posedge clk);
    repeat (fslc_pkg::LATENCY + 10) @(posedge clk);
    if (calls.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
